// ===== rtl/core/dgt_pkg.sv =====
// Package for the depth grid triangulator: shared widths, codes and the
// structs that pass between the core and its cell emitter. No dependencies.
`default_nettype none

package dgt_pkg;

	// Field widths fixed by the interface
	localparam int IDX_W      = 20;
	localparam int CNT_W      = 21;
	localparam int DEPTH_W    = 16;
	localparam int SIZE_W     = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd2;

	// Reset values of the configuration registers
	localparam logic [SIZE_W-1:0]  RST_GRID_WIDTH  = 11'd640;
	localparam logic [SIZE_W-1:0]  RST_GRID_HEIGHT = 11'd360;
	localparam logic [DEPTH_W-1:0] RST_THRESHOLD   = 16'd1;

	// Result kinds
	localparam logic KIND_TRI = 1'b0;
	localparam logic KIND_SUM = 1'b1;

	// One accepted sample, as handed to the cell emitter
	typedef struct packed {
		logic [IDX_W-1:0] tl_idx;      // top-left vertex index of the closed cell
		logic [IDX_W-1:0] w_idx;       // row width, for the index adds
		logic             closes_cell; // sample closes a cell
		logic             v_tl;        // top-left corner valid
		logic             v_bl;        // bottom-left corner valid
		logic             v_cur;       // this sample valid (bottom-right)
		logic             frame_end;   // last sample of the frame
	} dgt_item_t;

	// One result item
	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] vertex_a;
		logic [IDX_W-1:0] vertex_b;
		logic [IDX_W-1:0] vertex_c;
		logic [CNT_W-1:0] face_count;
		logic             last;
	} dgt_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/dgt_line_store.sv =====
// Line store: one valid flag per column of the previous row.
// Synchronous memory, read-before-write, registered read. No dependencies.
`default_nettype none

module dgt_line_store #(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     wdata,
	output logic                          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	// Read the old flag and store the new one at the same column
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q   <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/dgt_cell_emit.sv =====
// Cell emitter: holds one sample, issues its triangles and the frame summary
// one per cycle into the output register unless the output stalls. Depends on dgt_pkg.
`default_nettype none

module dgt_cell_emit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire dgt_pkg::dgt_item_t item,
	input  wire logic               top_right,
	output logic                    ready,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output dgt_pkg::dgt_result_t    result
);

	import dgt_pkg::*;

	logic        s1_valid_q;
	dgt_item_t   item_s1;
	logic [1:0]  sent_q;
	logic        out_valid_q;
	dgt_result_t res_q;
	logic [CNT_W-1:0] tot_q;

	logic        face1_ok, face2_ok, pend1, pend2, pend_sum, has;
	logic        out_free, emit, done;
	logic [IDX_W-1:0] tl_i, tr_i, bl_i, br_i;
	dgt_result_t nxt;

	// Pick the next result of the held sample
	always_comb begin
		face1_ok = item_s1.closes_cell & item_s1.v_tl & item_s1.v_bl & top_right;
		face2_ok = item_s1.closes_cell & item_s1.v_bl & item_s1.v_cur & top_right;
		pend1    = face1_ok & ~sent_q[0];
		pend2    = face2_ok & ~sent_q[1];
		pend_sum = item_s1.frame_end;
		has      = pend1 | pend2 | pend_sum;
		out_free = ~out_valid_q | ~out_stall;
		emit     = s1_valid_q & has & out_free;

		tl_i = item_s1.tl_idx;
		tr_i = tl_i + IDX_W'(1);
		bl_i = tl_i + item_s1.w_idx;
		br_i = bl_i + IDX_W'(1);

		nxt = '0;
		if (pend1) begin
			nxt.kind       = KIND_TRI;
			nxt.vertex_a   = tl_i;
			nxt.vertex_b   = bl_i;
			nxt.vertex_c   = tr_i;
			nxt.face_count = tot_q + CNT_W'(1);
			nxt.last       = ~(pend2 | pend_sum);
		end else if (pend2) begin
			nxt.kind       = KIND_TRI;
			nxt.vertex_a   = bl_i;
			nxt.vertex_b   = br_i;
			nxt.vertex_c   = tr_i;
			nxt.face_count = tot_q + CNT_W'(1);
			nxt.last       = ~pend_sum;
		end else begin
			nxt.kind       = KIND_SUM;
			nxt.face_count = tot_q;
			nxt.last       = 1'b1;
		end

		done  = s1_valid_q & (~has | (emit & nxt.last));
		ready = ~s1_valid_q | done;
	end

	// Hold the sample until its last result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			sent_q      <= '0;
			out_valid_q <= 1'b0;
			tot_q       <= '0;
		end else begin
			if (load)
				s1_valid_q <= 1'b1;
			else if (done)
				s1_valid_q <= 1'b0;

			if (load)
				sent_q <= '0;
			else if (emit && pend1)
				sent_q[0] <= 1'b1;
			else if (emit && pend2)
				sent_q[1] <= 1'b1;

			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			// Count faces; restart after the summary
			if (emit) begin
				if (nxt.kind == KIND_SUM)
					tot_q <= '0;
				else
					tot_q <= tot_q + CNT_W'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load)
			item_s1 <= item;
		if (emit)
			res_q <= nxt;
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/depth_grid_triangulator_core.sv =====
// Top level of the depth grid triangulator: configuration, raster counters,
// line store and cell emitter. Depends on dgt_pkg, dgt_line_store, dgt_cell_emit.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  depth
//   out       source     out_valid / out_stall kind, vertex_a/b/c, face_count, last
//   cfg       sink       cfg_we               cfg_index, cfg_data
//
// A sample stalls the input until its last result is issued; the single
// output register issues one result per cycle while out_stall is low. The
// next sample is taken while the last result waits. The line store is read
// and written in the cycle a sample is taken.
// Reset clears counters and control; the line store is not cleared.
// A stall on the output holds the result register and then the input.
`default_nettype none

module depth_grid_triangulator_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [dgt_pkg::DEPTH_W-1:0]        depth,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    kind,
	output logic [dgt_pkg::IDX_W-1:0]               vertex_a,
	output logic [dgt_pkg::IDX_W-1:0]               vertex_b,
	output logic [dgt_pkg::IDX_W-1:0]               vertex_c,
	output logic [dgt_pkg::CNT_W-1:0]               face_count,
	output logic                                    last,
	input  wire logic                               cfg_we,
	input  wire logic [dgt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dgt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import dgt_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = RW + WW;

	logic [SIZE_W-1:0]  gw_q, gh_q;
	logic [DEPTH_W-1:0] thr_q;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic               left_q;
	logic               diag_clr_q;

	logic [WW-1:0]      w;
	logic [HW-1:0]      h;
	logic               accept, ready, cur, row_end, frame_end, top_right;
	logic [RW-1:0]      row_m1;
	logic [PW-1:0]      prod;
	dgt_item_t          item;
	dgt_result_t        result;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q  <= RST_GRID_WIDTH;
			gh_q  <= RST_GRID_HEIGHT;
			thr_q <= RST_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:  gw_q  <= cfg_data[SIZE_W-1:0];
				REG_GRID_HEIGHT: gh_q  <= cfg_data[SIZE_W-1:0];
				REG_THRESHOLD:   thr_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Clamp the grid size and classify the sample
	always_comb begin
		if (32'(gw_q) < 32'd2)
			w = WW'(2);
		else if (32'(gw_q) > 32'(MAX_WIDTH))
			w = WW'(MAX_WIDTH);
		else
			w = WW'(gw_q);

		if (32'(gh_q) < 32'd2)
			h = HW'(2);
		else if (32'(gh_q) > 32'(MAX_HEIGHT))
			h = HW'(MAX_HEIGHT);
		else
			h = HW'(gh_q);

		cur       = depth >= thr_q;
		row_end   = 32'(col_q) >= 32'(w) - 32'd1;
		frame_end = row_end && (32'(row_q) >= 32'(h) - 32'd1);
		accept    = in_valid & ready;

		// Top-left index of the closed cell
		row_m1 = row_q - RW'(1);
		prod   = PW'(row_m1) * PW'(w);

		item.tl_idx      = IDX_W'(prod) + IDX_W'(col_q) - IDX_W'(1);
		item.w_idx       = IDX_W'(w);
		item.closes_cell = (row_q != '0) && (col_q != '0);
		item.v_tl        = ~diag_clr_q & top_right;
		item.v_bl        = left_q;
		item.v_cur       = cur;
		item.frame_end   = frame_end;
	end

	// Advance the raster position on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			left_q     <= 1'b0;
			diag_clr_q <= 1'b1;
		end else if (accept) begin
			if (frame_end) begin
				col_q      <= '0;
				row_q      <= '0;
				left_q     <= 1'b0;
				diag_clr_q <= 1'b1;
			end else if (row_end) begin
				col_q      <= '0;
				row_q      <= row_q + RW'(1);
				left_q     <= 1'b0;
				diag_clr_q <= 1'b1;
			end else begin
				col_q      <= col_q + CW'(1);
				left_q     <= cur;
				diag_clr_q <= 1'b0;
			end
		end
	end

	dgt_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.en    (accept),
		.addr  (col_q),
		.wdata (cur),
		.rdata (top_right)
	);

	dgt_cell_emit u_cell_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.item      (item),
		.top_right (top_right),
		.ready     (ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign in_stall   = ~ready;
	assign kind       = result.kind;
	assign vertex_a   = result.vertex_a;
	assign vertex_b   = result.vertex_b;
	assign vertex_c   = result.vertex_c;
	assign face_count = result.face_count;
	assign last       = result.last;

endmodule

`default_nettype wire

// ===== verif/depth_grid_triangulator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for depth_grid_triangulator_core: streams depth samples
// through the valid/stall ports and checks each face and frame summary against an
// in-bench mesh predictor. Depends on dgt_pkg and the core RTL.

module testbench;
	import dgt_pkg::*;

	localparam int MAX_W          = 1024;
	localparam int MAX_H          = 1024;
	localparam int RANDOM_SAMPLES = 200;
	localparam int WIDE_COLS      = 120;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 1000000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [DEPTH_W-1:0]    depth     = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  kind;
	logic [IDX_W-1:0]      vertex_a;
	logic [IDX_W-1:0]      vertex_b;
	logic [IDX_W-1:0]      vertex_c;
	logic [CNT_W-1:0]      face_count;
	logic                  last;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_GRID_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Predictor copy of the registers and the raster state
	logic [SIZE_W-1:0]  width_reg  = RST_GRID_WIDTH;
	logic [SIZE_W-1:0]  height_reg = RST_GRID_HEIGHT;
	logic [DEPTH_W-1:0] thresh_reg = RST_THRESHOLD;
	bit                 above_row [MAX_W];
	bit                 row_written [MAX_W];
	bit                 left_ok = 1'b0;
	bit                 diag_ok = 1'b0;
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;
	logic [CNT_W-1:0]   faces_in_frame = '0;

	dgt_result_t        faces_due[$];
	logic [DEPTH_W-1:0] depth_feed[$];
	int                 samples_fed   = 0;
	int                 samples_taken = 0;
	int                 in_idle       = 0;
	int                 out_idle      = 0;
	int                 in_gap        = 0;
	int                 stall_left    = 0;
	bit                 in_xfer       = 1'b0;
	int                 errors        = 0;
	int                 cycle_count   = 0;

	depth_grid_triangulator_core #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.depth(depth),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.vertex_a(vertex_a),
		.vertex_b(vertex_b),
		.vertex_c(vertex_c),
		.face_count(face_count),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_size(input logic [SIZE_W-1:0] raw, input int hi);
		if (raw < 2)
			return 2;
		if (raw > hi)
			return hi;
		return int'(raw);
	endfunction

	function automatic dgt_result_t make_face(input logic k, input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c,
			input logic [CNT_W-1:0] count);
		dgt_result_t f;
		f.kind       = k;
		f.vertex_a   = a;
		f.vertex_b   = b;
		f.vertex_c   = c;
		f.face_count = count;
		f.last       = 1'b0;
		return f;
	endfunction

	// Advance the mesh state by one sample and queue the faces it closes
	task automatic mesh_step(input logic [DEPTH_W-1:0] d);
		int w;
		int h;
		bit cur;
		bit top_right;
		bit row_end;
		bit frame_end;
		logic [IDX_W-1:0] tl_idx;
		logic [IDX_W-1:0] bl_idx;
		dgt_result_t burst[$];
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, MAX_H);
		cur = d >= thresh_reg;
		top_right = above_row[col_pos];
		row_end = col_pos >= w - 1;
		frame_end = row_end && row_pos >= h - 1;
		if (row_pos >= 1 && col_pos >= 1) begin
			tl_idx = IDX_W'((row_pos - 1) * w + (col_pos - 1));
			bl_idx = tl_idx + IDX_W'(w);
			if (diag_ok && left_ok && top_right) begin
				faces_in_frame++;
				burst = {burst, make_face(KIND_TRI, tl_idx, bl_idx,
					tl_idx + IDX_W'(1), faces_in_frame)};
			end
			if (left_ok && cur && top_right) begin
				faces_in_frame++;
				burst = {burst, make_face(KIND_TRI, bl_idx, bl_idx + IDX_W'(1),
					tl_idx + IDX_W'(1), faces_in_frame)};
			end
		end
		if (frame_end)
			burst = {burst, make_face(KIND_SUM, '0, '0, '0, faces_in_frame)};
		if (burst.size() != 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			faces_due = {faces_due, burst[i]};

		diag_ok = top_right;
		above_row[col_pos] = cur;
		row_written[col_pos] = 1'b1;
		left_ok = cur;
		if (frame_end) begin
			col_pos = 0;
			row_pos = 0;
			faces_in_frame = '0;
			left_ok = 1'b0;
			diag_ok = 1'b0;
		end else if (row_end) begin
			col_pos = 0;
			row_pos++;
			left_ok = 1'b0;
			diag_ok = 1'b0;
		end else begin
			col_pos++;
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function automatic int pick_gap(input int level);
		int roll;
		roll = $urandom_range(99);
		if (roll >= level)
			return 0;
		if (roll < level / 6)
			return $urandom_range(12, 6);
		return $urandom_range(3, 1);
	endfunction

	function automatic int idle_level();
		case ($urandom_range(3))
			0: return 0;
			1: return 15;
			2: return 40;
			default: return 70;
		endcase
	endfunction

	function automatic int pick_size(input int hi);
		if ($urandom_range(9) < 2)
			return $urandom_range(1, 0);
		return $urandom_range(hi, 2);
	endfunction

	// Samples left up to and including the one that ends the current frame
	function automatic int samples_to_frame_end();
		int w;
		int h;
		int row_rest;
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, MAX_H);
		row_rest = (col_pos >= w - 1) ? 1 : w - col_pos;
		return row_rest + ((row_pos >= h - 1) ? 0 : (h - 1 - row_pos) * w);
	endfunction

	// Columns of the line store written since reset, counted from column 0
	function automatic int written_prefix();
		int n;
		n = 0;
		while (n < MAX_W && row_written[n])
			n++;
		return n;
	endfunction

	function automatic logic [DEPTH_W-1:0] make_depth(input int valid_pct);
		if ($urandom_range(99) < 10)
			return DEPTH_W'($urandom);
		if (thresh_reg != 0 && $urandom_range(99) >= valid_pct)
			return DEPTH_W'($urandom_range(thresh_reg - 1, 0));
		return DEPTH_W'($urandom_range(16'hFFFF, thresh_reg));
	endfunction

	task automatic queue_samples(input int n, input int valid_pct);
		repeat (n)
			depth_feed = {depth_feed, make_depth(valid_pct)};
		samples_fed += n;
	endtask

	task automatic feed(input logic [DEPTH_W-1:0] vals[$]);
		foreach (vals[i])
			depth_feed = {depth_feed, vals[i]};
		samples_fed += vals.size();
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		// mirror the register in the predictor
		case (idx)
			REG_GRID_WIDTH: width_reg = value[SIZE_W-1:0];
			REG_GRID_HEIGHT: height_reg = value[SIZE_W-1:0];
			REG_THRESHOLD: thresh_reg = value[DEPTH_W-1:0];
			default: ;
		endcase
	endtask

	// Wait until every sample is taken and every face has come out, then drain
	task automatic wait_quiet();
		while (samples_taken != samples_fed || faces_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One frame with both sizes past their limits: the clamped width lets the
	// top row run on past WIDE_COLS, a narrower width then ends that row, and a
	// height of two ends the frame with the next row
	task automatic sweep_clamped_grid();
		in_idle = 10;
		out_idle = 10;
		if (col_pos != 0 || row_pos != 0) begin
			queue_samples(samples_to_frame_end(), 90);
			wait_quiet();
		end
		write_reg(REG_GRID_WIDTH, 16'd2047);
		write_reg(REG_GRID_HEIGHT, 16'd1500);
		write_reg(REG_THRESHOLD, 16'd1);
		queue_samples(WIDE_COLS, 95);
		wait_quiet();
		write_reg(REG_GRID_WIDTH, 16'(WIDE_COLS / 2));
		write_reg(REG_GRID_HEIGHT, 16'd2);
		queue_samples(samples_to_frame_end(), 95);
		wait_quiet();
	endtask

	// Drive samples at the falling edge; hold a stalled transfer
	always @(negedge clk) begin
		if (!in_valid || in_xfer) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (depth_feed.size() != 0) begin
				depth <= depth_feed.pop_front();
				in_valid <= 1'b1;
				in_gap = pick_gap(in_idle);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap(out_idle);
		end
	end

	// Predict on each input transfer, check each result transfer
	always @(posedge clk) begin : monitor
		dgt_result_t want;
		in_xfer <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			mesh_step(depth);
			samples_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (faces_due.size() == 0) begin
				$error("unexpected result: kind %0d a %0d b %0d c %0d count %0d last %0d",
					kind, vertex_a, vertex_b, vertex_c, face_count, last);
				errors++;
			end else begin
				want = faces_due.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("vertex_a", 32'(want.vertex_a), 32'(vertex_a));
				check_field("vertex_b", 32'(want.vertex_b), 32'(vertex_b));
				check_field("vertex_c", 32'(want.vertex_c), 32'(vertex_c));
				check_field("face_count", 32'(want.face_count), 32'(face_count));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		logic [DEPTH_W-1:0] burst[$];
		logic [DEPTH_W-1:0] thr;
		int w_raw;
		int h_raw;
		int n;
		int valid_pct;
		int rand_samples;
		bit big_done;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset sizes: row 0 only, threshold edge at one millimetre
		burst = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000};
		feed(burst);
		wait_quiet();

		// Shrink mid-row: the column counter is past the new end, so the row ends
		write_reg(REG_GRID_WIDTH, 16'd2);
		write_reg(REG_GRID_HEIGHT, 16'd2);
		burst = '{16'h0001, 16'h7FFF, 16'h00FF};
		feed(burst);
		wait_quiet();

		// Zero threshold: both faces and the summary from one sample
		write_reg(REG_THRESHOLD, 16'h0000);
		burst = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
		feed(burst);
		wait_quiet();

		// Top threshold: first face only, then second face only
		write_reg(REG_THRESHOLD, 16'hFFFF);
		burst = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE,
			16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		feed(burst);
		wait_quiet();

		// Three-wide frame: samples in row 0 and column 0 close no cell
		write_reg(REG_GRID_WIDTH, 16'd3);
		write_reg(REG_THRESHOLD, 16'h1000);
		burst = '{16'h1000, 16'h0FFF, 16'h1000, 16'h1000, 16'h1000, 16'h1000};
		feed(burst);
		wait_quiet();

		// Random phases: new sizes and threshold, whole or partial frames
		rand_samples = 0;
		big_done = 1'b0;
		while (rand_samples < RANDOM_SAMPLES) begin
			if (!big_done && rand_samples >= RANDOM_SAMPLES / 2) begin
				sweep_clamped_grid();
				big_done = 1'b1;
			end
			in_idle = idle_level();
			out_idle = idle_level();
			w_raw = pick_size(8);
			h_raw = pick_size(6);
			// never widen mid-frame past the columns the line store holds
			if (row_pos >= 1 && clamp_size(SIZE_W'(w_raw), MAX_W) > written_prefix())
				w_raw = 2;
			write_reg(REG_GRID_WIDTH, {5'($urandom), SIZE_W'(w_raw)});
			write_reg(REG_GRID_HEIGHT, {5'($urandom), SIZE_W'(h_raw)});
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(3))
					0: thr = 16'h0000;
					1: thr = 16'hFFFF;
					2: thr = DEPTH_W'($urandom_range(200, 1));
					default: thr = DEPTH_W'($urandom);
				endcase
				write_reg(REG_THRESHOLD, thr);
			end
			case ($urandom_range(3))
				0: valid_pct = 100;
				1: valid_pct = 90;
				2: valid_pct = 70;
				default: valid_pct = 40;
			endcase
			n = samples_to_frame_end() + $urandom_range(2) *
				clamp_size(width_reg, MAX_W) * clamp_size(height_reg, MAX_H);
			if ($urandom_range(3) == 0)
				n = $urandom_range(n, 1);
			queue_samples(n, valid_pct);
			rand_samples += n;
			wait_quiet();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/dgt_pkg.sv
rtl/core/dgt_line_store.sv
rtl/core/dgt_cell_emit.sv
rtl/core/depth_grid_triangulator_core.sv
verif/depth_grid_triangulator_tb.sv
